// ----- rtl/http_chunked_body_decoder_defines.svh -----
// Assertion macros shared by the chunked body decoder RTL.
// Each macro expects signals named clk and arst_n in the enclosing module.
`ifndef HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH
`define HTTP_CHUNKED_BODY_DECODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/chd_pkg.sv -----
// Types, codes and helper functions for the chunked body decoder.
// No dependencies; used by chd_front, chd_back and the top level.
`timescale 1ns / 1ps

package chd_pkg;

	localparam int unsigned ADDR_BITS = 3;
	localparam logic [ADDR_BITS-1:0] ADDR_BYTE_CAP = 3'd0;
	localparam logic [31:0] BYTE_CAP_RESET = 32'd65536;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;

	localparam logic [1:0] ST_RUN       = 2'd0;
	localparam logic [1:0] ST_DONE      = 2'd1;
	localparam logic [1:0] ST_NEED_MORE = 2'd2;
	localparam logic [1:0] ST_ERROR     = 2'd3;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
	localparam logic [1:0] ERR_MALFORMED = 2'd2;

	typedef enum logic [7:0] {
		PH_SIZE     = 8'b0000_0001,
		PH_DATA     = 8'b0000_0010,
		PH_TRAIL_CR = 8'b0000_0100,
		PH_TRAIL_LF = 8'b0000_1000,
		PH_FINAL_CR = 8'b0001_0000,
		PH_FINAL_LF = 8'b0010_0000,
		PH_DONE     = 8'b0100_0000,
		PH_ERROR    = 8'b1000_0000
	} phase_t;

	// One classified body byte as it sits in the queue.
	typedef struct packed {
		logic [7:0] body_byte;
		logic       last_byte;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_cr;
		logic       is_lf;
	} item_t;

	// Returns the digit value, or 16 for a byte that is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [7:0] d;
		begin
			d = 8'd16;
			if (b >= 8'h30 && b <= 8'h39) begin
				d = b - 8'h30;
			end else if (b >= 8'h61 && b <= 8'h66) begin
				d = b - 8'h57;
			end else if (b >= 8'h41 && b <= 8'h46) begin
				d = b - 8'h37;
			end
			hex_value = d[4:0];
		end
	endfunction

endpackage

// ----- rtl/chd_front.sv -----
// Front end of the chunked body decoder: accepts bytes, classifies them
// and holds them in a two-entry queue. Depends on chd_pkg.
`timescale 1ns / 1ps

module chd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     body_byte,
	input  logic           last_byte,
	output logic           q_valid,
	output chd_pkg::item_t q_head,
	input  logic           q_pop
);
	import chd_pkg::*;

	localparam int unsigned DEPTH = 2;

	item_t      mem_q [DEPTH];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;
	logic       push;
	item_t      item_in;
	logic [4:0] hv;

	always_comb begin
		hv = hex_value(body_byte);
		item_in.body_byte = body_byte;
		item_in.last_byte = last_byte;
		item_in.is_hex    = ~hv[4];
		item_in.hex_val   = hv[3:0];
		item_in.is_cr     = (body_byte == CH_CR);
		item_in.is_lf     = (body_byte == CH_LF);
	end

	assign in_stall = (count_q == 2'(DEPTH));
	assign push     = in_valid & ~in_stall;
	assign q_valid  = (count_q != 2'd0);
	assign q_head   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (q_pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 2'd1;
			end else if (q_pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- rtl/chd_back.sv -----
// Back end of the chunked body decoder: the parsing state machine, the
// counters and the output register. Depends on chd_pkg and the macro header.
`timescale 1ns / 1ps
`include "http_chunked_body_decoder_defines.svh"

module chd_back #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  chd_pkg::item_t q_head,
	output logic           q_pop,
	input  logic [31:0]    byte_cap,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     data_byte,
	output logic           data_valid,
	output logic [1:0]     status,
	output logic [1:0]     fault_code,
	output logic [31:0]    payload_total,
	output logic [31:0]    consumed_count
);
	import chd_pkg::*;

	localparam logic [31:0] U32_MAX = 32'hFFFF_FFFF;

	phase_t                phase_q, phase_d;
	logic [COUNT_BITS-1:0] size_q, size_d;
	logic                  hexst_q, hexst_d;
	logic [COUNT_BITS-1:0] left_q, left_d;
	logic [COUNT_BITS-1:0] total_q, total_d;
	logic [31:0]           written_q, written_d;
	logic [31:0]           consumed_q, consumed_d;

	logic                  out_valid_q;
	logic [7:0]            data_byte_q;
	logic                  data_valid_q;
	logic [1:0]            status_q;
	logic [1:0]            ecode_q;
	logic [31:0]           blen_q;
	logic [31:0]           cons_out_q;

	logic [7:0]            dbyte;
	logic                  dvalid;
	logic [1:0]            st;
	logic [1:0]            ec;
	logic [31:0]           blen;
	logic [31:0]           cons;
	logic [31:0]           cons_inc1;
	logic [31:0]           cons_inc2;
	logic [COUNT_BITS:0]   sum;
	logic [63:0]           total_ext;
	logic                  size_ovf;

	assign q_pop = q_valid & (~out_valid_q | ~out_stall);

	assign cons_inc1 = (consumed_q == U32_MAX) ? U32_MAX : consumed_q + 32'd1;
	assign cons_inc2 = (consumed_q > U32_MAX - 32'd2) ? U32_MAX : consumed_q + 32'd2;
	assign sum       = {1'b0, total_q} + {1'b0, size_q};
	// A new digit overflows exactly when the top nibble is already in use.
	assign size_ovf  = (size_q[COUNT_BITS-1 -: 4] != 4'd0);

	always_comb begin
		phase_d    = phase_q;
		size_d     = size_q;
		hexst_d    = hexst_q;
		left_d     = left_q;
		total_d    = total_q;
		written_d  = written_q;
		consumed_d = consumed_q;
		dbyte      = 8'd0;
		dvalid     = 1'b0;
		unique case (phase_q)
			PH_SIZE: begin
				consumed_d = cons_inc1;
				if (q_head.is_lf) begin
					hexst_d = 1'b0;
					if (size_q == '0) begin
						phase_d = PH_FINAL_CR;
					end else begin
						left_d  = size_q;
						phase_d = PH_DATA;
					end
				end else if (!hexst_q) begin
					if (q_head.is_hex) begin
						if (size_ovf) begin
							phase_d = PH_ERROR;
							hexst_d = 1'b0;
						end else begin
							size_d = {size_q[COUNT_BITS-5:0], q_head.hex_val};
						end
					end else begin
						hexst_d = 1'b1;
					end
				end
			end
			PH_DATA: begin
				consumed_d = cons_inc1;
				dbyte      = q_head.body_byte;
				if (written_q < byte_cap) begin
					dvalid    = 1'b1;
					written_d = written_q + 32'd1;
				end
				left_d = (left_q != '0) ? left_q - COUNT_BITS'(1) : left_q;
				if (left_q <= COUNT_BITS'(1)) begin
					hexst_d = 1'b0;
					phase_d = PH_TRAIL_CR;
				end
			end
			PH_TRAIL_CR: begin
				consumed_d = cons_inc1;
				hexst_d    = ~q_head.is_cr;
				phase_d    = PH_TRAIL_LF;
			end
			PH_TRAIL_LF: begin
				consumed_d = cons_inc1;
				if (sum[COUNT_BITS]) begin
					phase_d = PH_ERROR;
					hexst_d = 1'b0;
				end else if (hexst_q || !q_head.is_lf) begin
					phase_d = PH_ERROR;
					hexst_d = 1'b1;
				end else begin
					total_d = sum[COUNT_BITS-1:0];
					size_d  = '0;
					hexst_d = 1'b0;
					phase_d = PH_SIZE;
				end
			end
			PH_FINAL_CR: begin
				phase_d = q_head.is_cr ? PH_FINAL_LF : PH_DONE;
			end
			PH_FINAL_LF: begin
				if (q_head.is_lf) begin
					consumed_d = cons_inc2;
				end
				phase_d = PH_DONE;
			end
			PH_DONE, PH_ERROR: begin
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		total_ext = 64'(total_d);
		blen      = (total_ext > 64'h0000_0000_FFFF_FFFF) ? U32_MAX : total_ext[31:0];
		ec        = ERR_NONE;
		cons      = 32'd0;
		if (phase_d == PH_ERROR) begin
			st   = ST_ERROR;
			ec   = hexst_d ? ERR_MALFORMED : ERR_TOO_LARGE;
			blen = 32'd0;
		end else if (phase_d == PH_FINAL_CR || phase_d == PH_FINAL_LF ||
				phase_d == PH_DONE) begin
			st   = ST_DONE;
			cons = consumed_d;
		end else begin
			st = q_head.last_byte ? ST_NEED_MORE : ST_RUN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			size_q      <= '0;
			hexst_q     <= 1'b0;
			left_q      <= '0;
			total_q     <= '0;
			written_q   <= 32'd0;
			consumed_q  <= 32'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				phase_q     <= phase_d;
				size_q      <= size_d;
				hexst_q     <= hexst_d;
				left_q      <= left_d;
				total_q     <= total_d;
				written_q   <= written_d;
				consumed_q  <= consumed_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			data_byte_q  <= dbyte;
			data_valid_q <= dvalid;
			status_q     <= st;
			ecode_q      <= ec;
			blen_q       <= blen;
			cons_out_q   <= cons;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = data_byte_q;
	assign data_valid     = data_valid_q;
	assign status         = status_q;
	assign fault_code     = ecode_q;
	assign payload_total  = blen_q;
	assign consumed_count = cons_out_q;

	`CHD_ASSERT_NEXT(a_done_sticky, phase_q == PH_DONE, phase_q == PH_DONE, "done state was left")
	`CHD_ASSERT_NEXT(a_error_sticky, phase_q == PH_ERROR, phase_q == PH_ERROR, "error state was left")
	`CHD_ASSERT_NOW(a_data_in_progress, out_valid_q && data_valid_q, status_q == ST_RUN || status_q == ST_NEED_MORE, "payload byte with final status")
	`CHD_ASSERT_NOW(a_ecode_matches, out_valid_q, (status_q == ST_ERROR) == (ecode_q != ERR_NONE), "error code and status disagree")
	`CHD_ASSERT_NOW(a_count_only_done, out_valid_q && status_q != ST_DONE, cons_out_q == 32'd0, "consumed count shown before done")

endmodule

// ----- rtl/http_chunked_body_decoder.sv -----
// Top level of the HTTP/1.1 chunked body decoder.
// Path: each byte is registered in the chd_front queue and then in the chd_back output register.
// Throughput: one byte per clock, unless out_stall holds the output register in chd_back.
// Reset: arst_n clears all parse state and counters at once and sets byte_cap to
// 65536; there is no clearing pass, so bytes are taken from the first cycle after reset.
// Depends on chd_pkg, chd_front and chd_back.
`timescale 1ns / 1ps

module http_chunked_body_decoder #(
	parameter int unsigned COUNT_BITS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Byte input channel.
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     body_byte,
	input  logic                           last_byte,
	// Result channel, one result per input byte.
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     data_byte,
	output logic                           data_valid,
	output logic [1:0]                     status,
	output logic [1:0]                     fault_code,
	output logic [31:0]                    payload_total,
	output logic [31:0]                    consumed_count,
	// Configuration port.
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [chd_pkg::ADDR_BITS-1:0]  paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import chd_pkg::*;

	// The front end classifies each incoming byte (hex digit value, CR, LF)
	// and parks it in a two-entry queue. The back end pops one entry per
	// cycle whenever its output register is empty or being drained, so the
	// input side can still fill the queue while a finished result waits to be taken.

	logic [31:0] cap_q;
	logic        q_valid;
	item_t       q_head;
	logic        q_pop;
	logic        cfg_wr;

	// The only register is the byte cap. Writes must come only while the decoder
	// is idle; the block does not enforce this, and the back end reads it directly.
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;
	assign prdata = (paddr == ADDR_BYTE_CAP) ? cap_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= BYTE_CAP_RESET;
		end else if (cfg_wr && paddr == ADDR_BYTE_CAP) begin
			cap_q <= pwdata;
		end
	end

	chd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.body_byte (body_byte),
		.last_byte (last_byte),
		.q_valid   (q_valid),
		.q_head    (q_head),
		.q_pop     (q_pop)
	);

	// The back end holds the size, data and trailer phases. Once the body is
	// done or an error is found, later bytes are still taken and answered
	// with the held status until the next reset.
	chd_back #(
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_head         (q_head),
		.q_pop          (q_pop),
		.byte_cap       (cap_q),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.data_byte      (data_byte),
		.data_valid     (data_valid),
		.status         (status),
		.fault_code     (fault_code),
		.payload_total  (payload_total),
		.consumed_count (consumed_count)
	);

endmodule
